### src/crpo_pkg.sv
// Package: widths, register indexes, mode and status codes, and circle geometry type.
`default_nettype none
package crpo_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int COORD_W    = 13;
  localparam int DIM_W      = 12;
  localparam int TH_W       = 12;
  localparam int CS_W       = 7;
  localparam int SIZE_W     = 24;
  localparam int COLOR_W    = 8;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int GEO_W      = 16;
  localparam int SQ_W       = 27;
  localparam int RGB_W      = 3 * COLOR_W;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_CENTER = 2'd1;
  localparam logic [1:0] MODE_SQUARE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_AX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_AY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_BX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_BY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THICKNESS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_SEL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_SIZE  = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_MISORDER  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOTSQUARE = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADARG    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOFIT     = 3'd4;

  typedef struct packed {
    logic signed [GEO_W-1:0] a;
    logic signed [GEO_W-1:0] b;
    logic signed [GEO_W-1:0] big;
    logic [DIM_W:0]          w;
    logic [DIM_W:0]          h;
    logic [STAT_W-1:0]       status;
    logic [SQ_W-1:0]         r2;
    logic [SQ_W-1:0]         big2;
    logic [RGB_W-1:0]        line_rgb;
    logic [RGB_W-1:0]        fill_rgb;
    logic                    fill_en;
  } geom_t;

endpackage
`default_nettype wire

### src/crpo_if.sv
// Interfaces: pixel input channel and overlay result channel.
`default_nettype none
interface crpo_pix_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;

  modport source (output valid, pixel_x, pixel_y, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, pixel_x, pixel_y, in_red, in_green, in_blue, output ready);
endinterface

interface crpo_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [2:0] draw_status;

  modport source (output valid, out_red, out_green, out_blue, draw_status, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, draw_status, output ready);
endinterface
`default_nettype wire

### src/crpo_geom.sv
// Configuration registers and two-stage derivation of circle center, radii and status.
`default_nettype none
module crpo_geom (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [crpo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [crpo_pkg::CFG_DATA_W-1:0]  cfg_data,
  output crpo_pkg::geom_t                       geom
);
  import crpo_pkg::*;

  logic [1:0]         mode_r;
  logic [COORD_W-1:0] pax_r, pay_r, pbx_r, pby_r;
  logic [TH_W-1:0]    thick_r;
  logic [CS_W-1:0]    csel_r;
  logic [SIZE_W-1:0]  size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NONE;
      pax_r   <= '0;
      pay_r   <= '0;
      pbx_r   <= '0;
      pby_r   <= '0;
      thick_r <= TH_W'(1);
      csel_r  <= '0;
      size_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DRAW_MODE: mode_r  <= cfg_data[1:0];
        REG_POINT_AX:  pax_r   <= cfg_data[COORD_W-1:0];
        REG_POINT_AY:  pay_r   <= cfg_data[COORD_W-1:0];
        REG_POINT_BX:  pbx_r   <= cfg_data[COORD_W-1:0];
        REG_POINT_BY:  pby_r   <= cfg_data[COORD_W-1:0];
        REG_THICKNESS: thick_r <= cfg_data[TH_W-1:0];
        REG_COLOR_SEL: csel_r  <= cfg_data[CS_W-1:0];
        REG_IMG_SIZE:  size_r  <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // first derivation stage: center, inner and outer radius, mode status
  logic signed [GEO_W-1:0] x1, y1, x2, y2, thick, diff_x, diff_y;
  logic signed [GEO_W-1:0] a_nxt, b_nxt, r_nxt, big_nxt;
  logic [STAT_W-1:0]       pre_nxt;

  always_comb begin
    x1      = GEO_W'($signed(pax_r));
    y1      = GEO_W'($signed(pay_r));
    x2      = GEO_W'($signed(pbx_r));
    y2      = GEO_W'($signed(pby_r));
    thick   = $signed({{(GEO_W-TH_W){1'b0}}, thick_r});
    diff_x  = x2 - x1;
    diff_y  = y1 - y2;
    a_nxt   = '0;
    b_nxt   = '0;
    r_nxt   = '0;
    big_nxt = '0;
    pre_nxt = ST_OK;
    priority if (mode_r == MODE_CENTER) begin
      r_nxt   = x2;
      big_nxt = x2 + thick;
      a_nxt   = x1;
      b_nxt   = y1;
    end else if (mode_r == MODE_SQUARE && (pax_r | pay_r | pbx_r | pby_r) != '0) begin
      priority if (x2 < x1 || y2 > y1) begin
        pre_nxt = ST_MISORDER;
      end else if (diff_x != diff_y) begin
        pre_nxt = ST_NOTSQUARE;
      end else begin
        r_nxt   = diff_x >>> 1;  // side is nonnegative here
        big_nxt = (diff_x >>> 1) + thick;
        a_nxt   = x1 + (diff_x >>> 1);
        b_nxt   = y1 - (diff_x >>> 1);
      end
    end else begin
      pre_nxt = ST_BADARG;
    end
  end

  logic signed [GEO_W-1:0] a_r, b_r, r_r, big_r;
  logic [STAT_W-1:0]       pre_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r   <= '0;
      b_r   <= '0;
      r_r   <= '0;
      big_r <= '0;
      pre_r <= ST_BADARG;
    end else begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      r_r   <= r_nxt;
      big_r <= big_nxt;
      pre_r <= pre_nxt;
    end
  end

  logic [DIM_W:0] w_c, h_c;
  assign w_c = ({1'b0, size_r[DIM_W-1:0]} > (DIM_W+1)'(MAX_DIM)) ?
               (DIM_W+1)'(MAX_DIM) : {1'b0, size_r[DIM_W-1:0]};
  assign h_c = ({1'b0, size_r[2*DIM_W-1:DIM_W]} > (DIM_W+1)'(MAX_DIM)) ?
               (DIM_W+1)'(MAX_DIM) : {1'b0, size_r[2*DIM_W-1:DIM_W]};

  // second stage: fit check and squared radii
  logic signed [GEO_W-1:0]   w_s, h_s;
  logic signed [2*GEO_W-1:0] r_prod, big_prod;
  logic [STAT_W-1:0]         status_nxt;

  always_comb begin
    w_s      = $signed({{(GEO_W-DIM_W-1){1'b0}}, w_c});
    h_s      = $signed({{(GEO_W-DIM_W-1){1'b0}}, h_c});
    r_prod   = r_r * r_r;
    big_prod = big_r * big_r;
    status_nxt = pre_r;
    if (pre_r == ST_OK &&
        (a_r < big_r || b_r < big_r || b_r + big_r > h_s || a_r + big_r > w_s))
      status_nxt = ST_NOFIT;
  end

  logic [STAT_W-1:0] status_r;
  logic [SQ_W-1:0]   r2_r, big2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= ST_BADARG;
      r2_r     <= '0;
      big2_r   <= '0;
    end else begin
      status_r <= status_nxt;
      r2_r     <= r_prod[SQ_W-1:0];
      big2_r   <= big_prod[SQ_W-1:0];
    end
  end

  always_comb begin
    geom.a        = a_r;
    geom.b        = b_r;
    geom.big      = big_r;
    geom.w        = w_c;
    geom.h        = h_c;
    geom.status   = status_r;
    geom.r2       = r2_r;
    geom.big2     = big2_r;
    geom.line_rgb = {{COLOR_W{csel_r[0]}}, {COLOR_W{csel_r[1]}}, {COLOR_W{csel_r[2]}}};
    geom.fill_rgb = {{COLOR_W{csel_r[3]}}, {COLOR_W{csel_r[4]}}, {COLOR_W{csel_r[5]}}};
    geom.fill_en  = csel_r[6];
  end

endmodule
`default_nettype wire

### src/circle_ring_pixel_overlay.sv
// Circle ring pixel overlay: four-stage pixel pipeline with per-stage valid and ready.
// A word accepted at the input passes through stage registers 1 to 4; stage 4 is the output register.
// One word per cycle while the output accepts; each stage holds one word and advances when the next
// stage is free, so bubbles are squeezed out while the output stalls.
// Reset (synchronous, rst_n low): registers to defaults, thickness one, pipeline empty.
// Derived circle values follow a register write through the center and radius registers, then status and squared radii.
`default_nettype none
module circle_ring_pixel_overlay (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [crpo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [crpo_pkg::CFG_DATA_W-1:0]  cfg_data,
  crpo_pix_in_if.sink                           in_ch,
  crpo_pix_out_if.source                        out_ch
);
  import crpo_pkg::*;

  geom_t geom;

  crpo_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_r || out_ch.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  // stage 1: capture
  logic [DIM_W-1:0] px1_r, py1_r;
  logic [RGB_W-1:0] rgb1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (rdy1) v1_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      px1_r  <= in_ch.pixel_x;
      py1_r  <= in_ch.pixel_y;
      rgb1_r <= {in_ch.in_red, in_ch.in_green, in_ch.in_blue};
    end
  end

  // stage 2: offsets from center, image and bounding box check
  logic signed [GEO_W-1:0] dx_nxt, dy_nxt;
  logic                    cand_nxt;

  always_comb begin
    dx_nxt   = $signed({{(GEO_W-DIM_W){1'b0}}, px1_r}) - geom.a;
    dy_nxt   = $signed({{(GEO_W-DIM_W){1'b0}}, py1_r}) - geom.b;
    cand_nxt = ({1'b0, px1_r} < geom.w) && ({1'b0, py1_r} < geom.h) &&
               (dx_nxt <= geom.big) && (dx_nxt >= -geom.big) &&
               (dy_nxt <= geom.big) && (dy_nxt >= -geom.big);
  end

  logic signed [GEO_W-1:0] dx2_r, dy2_r;
  logic                    cand2_r;
  logic [RGB_W-1:0]        rgb2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (rdy2) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      dx2_r   <= dx_nxt;
      dy2_r   <= dy_nxt;
      cand2_r <= cand_nxt;
      rgb2_r  <= rgb1_r;
    end
  end

  // stage 3: squares
  logic signed [2*GEO_W-1:0] sqx, sqy;
  assign sqx = dx2_r * dx2_r;
  assign sqy = dy2_r * dy2_r;

  logic [SQ_W-1:0]   sqx3_r, sqy3_r;
  logic              hit3_r;
  logic [RGB_W-1:0]  rgb3_r;
  logic [STAT_W-1:0] stat3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (rdy3) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      sqx3_r  <= sqx[SQ_W-1:0];
      sqy3_r  <= sqy[SQ_W-1:0];
      hit3_r  <= cand2_r && (geom.status == ST_OK);
      rgb3_r  <= rgb2_r;
      stat3_r <= geom.status;
    end
  end

  // stage 4: ring and fill decision into the output register
  logic [SQ_W-1:0]  d2;
  logic [RGB_W-1:0] rgb_nxt;

  always_comb begin
    d2 = sqx3_r + sqy3_r;  // both below 2**26 for a candidate pixel
    priority if (hit3_r && d2 < geom.big2 && d2 >= geom.r2)
      rgb_nxt = geom.line_rgb;
    else if (hit3_r && geom.fill_en && d2 < geom.r2)
      rgb_nxt = geom.fill_rgb;
    else
      rgb_nxt = rgb3_r;
  end

  logic [RGB_W-1:0]  rgb4_r;
  logic [STAT_W-1:0] stat4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (rdy4) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      rgb4_r  <= rgb_nxt;
      stat4_r <= stat3_r;
    end
  end

  assign out_ch.valid       = v4_r;
  assign out_ch.out_red     = rgb4_r[3*COLOR_W-1:2*COLOR_W];
  assign out_ch.out_green   = rgb4_r[2*COLOR_W-1:COLOR_W];
  assign out_ch.out_blue    = rgb4_r[COLOR_W-1:0];
  assign out_ch.draw_status = stat4_r;

endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench for the circle ring overlay: directed and random pixels checked against a recolor predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import crpo_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 15;
  localparam int WORDS_PER_PHASE = 30;
  localparam logic [COLOR_W-1:0] FULL = 8'hFF;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [DIM_W-1:0]   x;
    logic [DIM_W-1:0]   y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [STAT_W-1:0]  status;
  } shade_t;

  class ring_overlay_scoreboard;
    logic [1:0]         mode;
    logic [COORD_W-1:0] ax, ay, bx, by;
    logic [TH_W-1:0]    thick;
    logic [CS_W-1:0]    csel;
    logic [SIZE_W-1:0]  isize;
    shade_t             expected_shades[$];
    int                 mismatches;

    function new();
      mode = MODE_NONE;
      ax = '0;
      ay = '0;
      bx = '0;
      by = '0;
      thick = TH_W'(1);
      csel = '0;
      isize = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DRAW_MODE: mode = val[1:0];
        REG_POINT_AX:  ax = val[COORD_W-1:0];
        REG_POINT_AY:  ay = val[COORD_W-1:0];
        REG_POINT_BX:  bx = val[COORD_W-1:0];
        REG_POINT_BY:  by = val[COORD_W-1:0];
        REG_THICKNESS: thick = val[TH_W-1:0];
        REG_COLOR_SEL: csel = val[CS_W-1:0];
        REG_IMG_SIZE:  isize = val[SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    function shade_t recolor(pixel_t p);
      longint px, py, w, h, t, r, big, a, b, x1, y1, x2, y2, dx, dy, d2;
      logic [STAT_W-1:0] st;
      shade_t res;
      px = longint'(p.x);
      py = longint'(p.y);
      w = longint'(isize[DIM_W-1:0]);
      h = longint'(isize[SIZE_W-1:DIM_W]);
      t = longint'(thick);
      r = 0;
      big = 0;
      a = 0;
      b = 0;
      st = ST_OK;
      res.red = p.red;
      res.green = p.green;
      res.blue = p.blue;
      if (w > MAX_DIM) w = longint'(MAX_DIM);
      if (h > MAX_DIM) h = longint'(MAX_DIM);

      if (mode == MODE_CENTER) begin
        r = longint'($signed(bx));
        big = r + t;
        a = longint'($signed(ax));
        b = longint'($signed(ay));
      end else if (mode == MODE_SQUARE && (ax | ay | bx | by) != '0) begin
        x1 = longint'($signed(ax));
        y1 = longint'($signed(ay));
        x2 = longint'($signed(bx));
        y2 = longint'($signed(by));
        if (x2 < x1 || y2 > y1) begin
          st = ST_MISORDER;
        end else if (x2 - x1 != y1 - y2) begin
          st = ST_NOTSQUARE;
        end else begin
          r = (x2 - x1) / 2;
          big = r + t;
          a = x1 + r;
          b = y1 - r;
        end
      end else begin
        st = ST_BADARG;
      end

      if (st == ST_OK && (a < big || b < big || b + big > h || a + big > w))
        st = ST_NOFIT;

      if (st == ST_OK && px < w && py < h) begin
        dx = px - a;
        dy = py - b;
        if ((dx < 0 ? -dx : dx) <= big && (dy < 0 ? -dy : dy) <= big) begin
          d2 = dx * dx + dy * dy;
          if (d2 < big * big && d2 >= r * r) begin
            res.red   = csel[0] ? FULL : '0;
            res.green = csel[1] ? FULL : '0;
            res.blue  = csel[2] ? FULL : '0;
          end else if (csel[6] && d2 < r * r) begin
            res.red   = csel[3] ? FULL : '0;
            res.green = csel[4] ? FULL : '0;
            res.blue  = csel[5] ? FULL : '0;
          end
        end
      end
      res.status = st;
      return res;
    endfunction

    function void note_pixel(pixel_t p);
      expected_shades.push_back(recolor(p));
    endfunction

    function void check_shade(shade_t got);
      shade_t want;
      if (expected_shades.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: rgb %h %h %h status %0d",
                   got.red, got.green, got.blue, got.status);
        return;
      end
      want = expected_shades.pop_front();
      if (got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected rgb %h %h %h status %0d, got rgb %h %h %h status %0d",
                   want.red, want.green, want.blue, want.status,
                   got.red, got.green, got.blue, got.status);
      end
    endfunction

    function int pending();
      return expected_shades.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  crpo_pix_in_if  in_ch();
  crpo_pix_out_if out_ch();

  circle_ring_pixel_overlay dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  ring_overlay_scoreboard sb = new();

  int tx_idle_pct = 27;
  int rx_idle_pct = 54;
  int sent = 0;
  int cycle_count = 0;
  int aim_a, aim_b, aim_span;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_shade(shade_t'{out_ch.out_red, out_ch.out_green, out_ch.out_blue,
                              out_ch.draw_status});
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_pixel(input pixel_t p);
    if (sent < 150) begin
      tx_idle_pct = 27;
      rx_idle_pct = 54;
    end else if (sent < 300) begin
      tx_idle_pct = 54;
      rx_idle_pct = 27;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.pixel_x = p.x;
    in_ch.pixel_y = p.y;
    in_ch.in_red = p.red;
    in_ch.in_green = p.green;
    in_ch.in_blue = p.blue;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_pixel(p);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    sb.set_reg(idx, val);
  endtask

  // registers change only with the pipeline empty; sending resumes only after derived values follow
  task automatic setup(input logic [1:0] mode, input logic [CFG_DATA_W-1:0] ax,
                       input logic [CFG_DATA_W-1:0] ay, input logic [CFG_DATA_W-1:0] bx,
                       input logic [CFG_DATA_W-1:0] by, input logic [CFG_DATA_W-1:0] thick,
                       input logic [CFG_DATA_W-1:0] csel, input logic [CFG_DATA_W-1:0] isize);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    write_reg(REG_DRAW_MODE, {22'd0, mode});
    write_reg(REG_POINT_AX, ax);
    write_reg(REG_POINT_AY, ay);
    write_reg(REG_POINT_BX, bx);
    write_reg(REG_POINT_BY, by);
    write_reg(REG_THICKNESS, thick);
    write_reg(REG_COLOR_SEL, csel);
    write_reg(REG_IMG_SIZE, isize);
    cfg_we = 1'b0;
    repeat (4) @(negedge clk);
  endtask

  // mostly pixels around the circle's bounding box, some anywhere
  task automatic send_aimed();
    int x, y;
    pixel_t p;
    if ($urandom_range(99) < 85) begin
      x = aim_a + int'($urandom_range(2 * aim_span)) - aim_span;
      y = aim_b + int'($urandom_range(2 * aim_span)) - aim_span;
      if (x < 0) x = 0;
      if (x > 4095) x = 4095;
      if (y < 0) y = 0;
      if (y > 4095) y = 4095;
    end else begin
      x = $urandom_range(4095);
      y = $urandom_range(4095);
    end
    p.x = x[DIM_W-1:0];
    p.y = y[DIM_W-1:0];
    p.red = COLOR_W'($urandom_range(255));
    p.green = COLOR_W'($urandom_range(255));
    p.blue = COLOR_W'($urandom_range(255));
    send_pixel(p);
  endtask

  task automatic random_phase();
    int w, h, m, t, r, big, lo, a, b, side;
    logic [CS_W-1:0] cs;
    if ($urandom_range(3) != 0) begin
      w = $urandom_range(4095, 32);
      h = $urandom_range(4095, 32);
      m = (w < h) ? w : h;
      t = $urandom_range(m / 4);
      if ($urandom_range(3) == 0) t = $urandom_range(3);
      r = int'($urandom_range(m / 4 + 8)) - 8;
      cs = CS_W'($urandom_range(127));
      if ($urandom_range(1) == 1) begin
        if (r < 0) r = -r;
        big = r + t;
        a = $urandom_range(w - big, big);
        b = $urandom_range(h - big, big);
        // odd side keeps the far corner inside the coordinate range only when t > 0
        side = 2 * r + ((t > 0) ? int'($urandom_range(1)) : 0);
        setup(MODE_SQUARE, CFG_DATA_W'(a - r), CFG_DATA_W'(b + r),
              CFG_DATA_W'(a - r + side), CFG_DATA_W'(b + r - side),
              CFG_DATA_W'(t), CFG_DATA_W'(cs), {h[DIM_W-1:0], w[DIM_W-1:0]});
        lo = big;
      end else begin
        big = r + t;
        lo = (big > 0) ? big : 0;
        a = $urandom_range(w - lo, lo);
        b = $urandom_range(h - lo, lo);
        setup(MODE_CENTER, CFG_DATA_W'(a), CFG_DATA_W'(b), CFG_DATA_W'(r),
              CFG_DATA_W'($urandom_range(8191)), CFG_DATA_W'(t), CFG_DATA_W'(cs),
              {h[DIM_W-1:0], w[DIM_W-1:0]});
      end
      aim_a = a;
      aim_b = b;
      aim_span = lo + 3;
    end else begin
      setup(2'($urandom_range(3)), CFG_DATA_W'($urandom_range(8191)),
            CFG_DATA_W'($urandom_range(8191)), CFG_DATA_W'($urandom_range(8191)),
            CFG_DATA_W'($urandom_range(8191)), CFG_DATA_W'($urandom_range(4095)),
            CFG_DATA_W'($urandom_range(127)), CFG_DATA_W'($urandom_range(24'hFFFFFF)));
      aim_a = $urandom_range(4095);
      aim_b = $urandom_range(4095);
      aim_span = $urandom_range(64);
    end
    repeat (WORDS_PER_PHASE) send_aimed();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_DRAW_MODE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.pixel_x = '0;
    in_ch.pixel_y = '0;
    in_ch.in_red = '0;
    in_ch.in_green = '0;
    in_ch.in_blue = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    repeat (4) @(negedge clk);

    // registers at reset: no mode given
    send_pixel(pixel_t'{12'd0, 12'd0, 8'h00, 8'h00, 8'h00});
    send_pixel(pixel_t'{12'd4095, 12'd4095, 8'hFF, 8'hFF, 8'hFF});

    // center and radius with fill: center, ring edge, inside the ring, box edge, off image
    setup(MODE_CENTER, 100, 100, 20, 0, 5, 7'b1010101, {12'd200, 12'd200});
    send_pixel(pixel_t'{12'd100, 12'd100, 8'h12, 8'h34, 8'h56});
    send_pixel(pixel_t'{12'd120, 12'd100, 8'h00, 8'hFF, 8'h00});
    send_pixel(pixel_t'{12'd100, 12'd79, 8'hFF, 8'h00, 8'hFF});
    send_pixel(pixel_t'{12'd125, 12'd100, 8'hAA, 8'h55, 8'hAA});
    send_pixel(pixel_t'{12'd200, 12'd100, 8'h01, 8'h02, 8'h03});

    // square corners: x misordered, y misordered, not square, all zero
    setup(MODE_SQUARE, 50, 150, 40, 50, 1, 7'h7F, {12'd300, 12'd300});
    send_pixel(pixel_t'{12'd45, 12'd100, 8'h11, 8'h22, 8'h33});
    setup(MODE_SQUARE, 50, 150, 150, 160, 1, 7'h7F, {12'd300, 12'd300});
    send_pixel(pixel_t'{12'd100, 12'd155, 8'h11, 8'h22, 8'h33});
    setup(MODE_SQUARE, 50, 150, 150, 60, 1, 7'h7F, {12'd300, 12'd300});
    send_pixel(pixel_t'{12'd100, 12'd100, 8'h11, 8'h22, 8'h33});
    setup(MODE_SQUARE, 0, 0, 0, 0, 1, 7'h7F, {12'd300, 12'd300});
    send_pixel(pixel_t'{12'd0, 12'd0, 8'h11, 8'h22, 8'h33});

    // unused mode code
    setup(MODE_SPARE, 100, 100, 20, 0, 5, 7'h7F, {12'd200, 12'd200});
    send_pixel(pixel_t'{12'd120, 12'd100, 8'h44, 8'h55, 8'h66});

    // odd side rounds the radius down; fill disabled
    setup(MODE_SQUARE, 10, 111, 111, 10, 3, 7'b0111111, {12'd128, 12'd128});
    send_pixel(pixel_t'{12'd60, 12'd61, 8'h77, 8'h88, 8'h99});
    send_pixel(pixel_t'{12'd110, 12'd61, 8'h77, 8'h88, 8'h99});

    // negative radius on the largest image: only fill can apply
    setup(MODE_CENTER, 10, 10, -5, 0, 10, 7'h7F, 24'hFFFFFF);
    send_pixel(pixel_t'{12'd10, 12'd10, 8'h00, 8'h00, 8'h00});
    send_pixel(pixel_t'{12'd15, 12'd10, 8'h00, 8'h00, 8'h00});

    // extreme points and thickness, empty image: does not fit
    setup(MODE_CENTER, -4096, 4095, 4095, -1, 4095, 7'h00, 24'h000000);
    send_pixel(pixel_t'{12'd0, 12'd4095, 8'hFF, 8'h00, 8'hFF});

    // zero thickness: ring is empty
    setup(MODE_CENTER, 50, 50, 10, 0, 0, 7'b1000111, {12'd100, 12'd100});
    send_pixel(pixel_t'{12'd60, 12'd50, 8'hC0, 8'hC1, 8'hC2});
    send_pixel(pixel_t'{12'd55, 12'd50, 8'hC0, 8'hC1, 8'hC2});

    repeat (RANDOM_PHASES) random_phase();

    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
src/crpo_pkg.sv
src/crpo_if.sv
src/crpo_geom.sv
src/circle_ring_pixel_overlay.sv
tb/testbench.sv
